### rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// shared widths, types and helpers for the barometric compensation block
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = $clog2(WORD_W);

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic  start;
        t_word dividend;
        t_word divisor;
    } t_div_req;

    typedef struct packed {
        logic  done;
        t_word quotient;
    } t_div_rsp;

    function automatic t_word asr(input t_word v, input logic [CNT_W-1:0] n);
        asr = t_word'($signed(v) >>> n);
    endfunction

    function automatic t_word sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    function automatic t_word zx16(input logic [15:0] v);
        zx16 = {16'd0, v};
    endfunction

endpackage

### rtl/baro_pressure_temp_compensation.sv
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// barometer temperature and pressure compensation on a shared multiplier
// ----------------------------------------------------------------------------
// usage:
//   cfg channel writes calibration words and the oversampling setting,
//   index 0..3; writes take effect at once, so they belong between words.
//   input word: tuser is the kind (0 temperature, 1 pressure), tdata the raw
//   reading. one result word per input word.
//   a temperature word and a pressure word each pass the 32-step divider and
//   the steps of the one 32x32 multiplier, a pressure word more of them. the
//   block takes one word at a time and is not ready while it works.
//   the result sits in an output register; a stalled receiver holds the block
//   in its final step until the word is taken, a new input is accepted once
//   the result is loaded.
//   reset clears the calibration words, the oversampling setting and the
//   stored b5 term to zero.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // raw_reading[23:0]
    input  logic        i_s_axis_tuser,   // func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // temperature_dc[15:0], pressure_pa[33:16],
                                          // div_error[34], zero pad
    output logic        o_m_axis_tuser    // kind
);

    localparam logic [2:0] REG_A   = 3'd0;
    localparam logic [2:0] REG_B   = 3'd1;
    localparam logic [2:0] REG_C   = 3'd2;
    localparam logic [2:0] REG_OSS = 3'd3;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_T0   = 5'd1;
    localparam logic [4:0] S_T1   = 5'd2;
    localparam logic [4:0] S_TW   = 5'd3;
    localparam logic [4:0] S_P0   = 5'd4;
    localparam logic [4:0] S_P1   = 5'd5;
    localparam logic [4:0] S_P2   = 5'd6;
    localparam logic [4:0] S_P3   = 5'd7;
    localparam logic [4:0] S_P4   = 5'd8;
    localparam logic [4:0] S_P5   = 5'd9;
    localparam logic [4:0] S_P6   = 5'd10;
    localparam logic [4:0] S_P7   = 5'd11;
    localparam logic [4:0] S_PW   = 5'd12;
    localparam logic [4:0] S_P8   = 5'd13;
    localparam logic [4:0] S_P9   = 5'd14;
    localparam logic [4:0] S_P10  = 5'd15;
    localparam logic [4:0] S_P11  = 5'd16;
    localparam logic [4:0] S_DONE = 5'd17;

    localparam bpc_pkg::t_word C_4000  = 32'd4000;
    localparam bpc_pkg::t_word C_32768 = 32'd32768;
    localparam bpc_pkg::t_word C_50000 = 32'd50000;
    localparam bpc_pkg::t_word C_3038  = 32'd3038;
    localparam bpc_pkg::t_word C_M7357 = 32'hFFFF_E343;
    localparam bpc_pkg::t_word C_3791  = 32'd3791;
    localparam bpc_pkg::t_word C_PMAX  = 32'd262143;

    logic [63:0]     r_cal_a;
    logic [63:0]     r_cal_b;
    logic [31:0]     r_cal_c;
    logic [1:0]      r_oss;
    bpc_pkg::t_word  r_b5;

    logic [4:0]      r_state;
    logic            r_kind;
    logic [23:0]     r_raw;
    bpc_pkg::t_word  r_prod;
    bpc_pkg::t_word  r_x1;
    bpc_pkg::t_word  r_sq;
    bpc_pkg::t_word  r_b3;
    bpc_pkg::t_word  r_b4;
    bpc_pkg::t_word  r_b7;
    bpc_pkg::t_word  r_b6;
    bpc_pkg::t_word  r_p;
    logic            r_neg;
    logic [15:0]     r_temp;
    logic [17:0]     r_press;
    logic            r_err;

    logic            r_ovalid;
    logic [39:0]     r_odata;
    logic            r_ouser;

    bpc_pkg::t_word  w_ac1, w_ac2, w_ac3, w_ac4, w_ac5, w_ac6;
    bpc_pkg::t_word  w_b1, w_b2, w_mc, w_md;
    bpc_pkg::t_word  w_ma, w_mb;
    bpc_pkg::t_word  w_up;
    bpc_pkg::t_word  w_x1t, w_den, w_num, w_q, w_b5n, w_tn;
    bpc_pkg::t_word  w_x3, w_b3n, w_x3b, w_pn;
    bpc_pkg::t_div_req w_req;
    bpc_pkg::t_div_rsp w_rsp;
    logic            w_in_acc;

    assign w_ac1 = bpc_pkg::sx16(r_cal_a[15:0]);
    assign w_ac2 = bpc_pkg::sx16(r_cal_a[31:16]);
    assign w_ac3 = bpc_pkg::sx16(r_cal_a[47:32]);
    assign w_ac4 = bpc_pkg::zx16(r_cal_a[63:48]);
    assign w_ac5 = bpc_pkg::zx16(r_cal_b[15:0]);
    assign w_ac6 = bpc_pkg::zx16(r_cal_b[31:16]);
    assign w_b1  = bpc_pkg::sx16(r_cal_b[47:32]);
    assign w_b2  = bpc_pkg::sx16(r_cal_b[63:48]);
    assign w_mc  = bpc_pkg::sx16(r_cal_c[15:0]);
    assign w_md  = bpc_pkg::sx16(r_cal_c[31:16]);

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_up  = {8'd0, r_raw} >> (4'd8 - {2'b00, r_oss});
    assign w_x1t = bpc_pkg::asr(r_prod, 5'd15);
    assign w_den = w_x1t + w_md;
    assign w_num = {w_mc[20:0], 11'd0};
    assign w_q   = r_neg ? (32'd0 - w_rsp.quotient) : w_rsp.quotient;
    assign w_b5n = r_x1 + w_q;
    assign w_tn  = bpc_pkg::asr(w_b5n + 32'd8, 5'd4);
    assign w_x3  = r_x1 + bpc_pkg::asr(r_prod, 5'd11);
    assign w_b3n = bpc_pkg::asr((({w_ac1[29:0], 2'b00} + w_x3) << r_oss) + 32'd2, 5'd2);
    assign w_x3b = bpc_pkg::asr(r_x1 + bpc_pkg::asr(r_prod, 5'd16) + 32'd2, 5'd2);
    assign w_pn  = r_p + bpc_pkg::asr(r_x1 + bpc_pkg::asr(r_prod, 5'd16) + C_3791, 5'd4);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_T0: begin
                w_ma = {16'd0, r_raw[15:0]} - w_ac6;
                w_mb = w_ac5;
            end
            S_P0: begin
                w_ma = r_b6;
                w_mb = r_b6;
            end
            S_P1: begin
                w_ma = w_b2;
                w_mb = bpc_pkg::asr(r_prod, 5'd12);
            end
            S_P2: begin
                w_ma = w_ac2;
                w_mb = r_b6;
            end
            S_P3: begin
                w_ma = w_ac3;
                w_mb = r_b6;
            end
            S_P4: begin
                w_ma = w_b1;
                w_mb = r_sq;
            end
            S_P5: begin
                w_ma = w_ac4;
                w_mb = w_x3b + C_32768;
            end
            S_P6: begin
                w_ma = w_up - r_b3;
                w_mb = C_50000 >> r_oss;
            end
            S_P8: begin
                w_ma = bpc_pkg::asr(r_p, 5'd8);
                w_mb = bpc_pkg::asr(r_p, 5'd8);
            end
            S_P9: begin
                w_ma = r_prod;
                w_mb = C_3038;
            end
            S_P10: begin
                w_ma = C_M7357;
                w_mb = r_p;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_comb begin
        w_req.start    = 1'b0;
        w_req.dividend = '0;
        w_req.divisor  = '0;
        if (r_state == S_T1) begin
            w_req.start    = (w_den != '0);
            w_req.dividend = w_num[31] ? (32'd0 - w_num) : w_num;
            w_req.divisor  = w_den[31] ? (32'd0 - w_den) : w_den;
        end else if (r_state == S_P7) begin
            w_req.start    = (r_b4 != '0);
            w_req.dividend = r_prod[31] ? r_prod : {r_prod[30:0], 1'b0};
            w_req.divisor  = r_b4;
        end
    end

    bpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
            r_oss   <= '0;
        end else if (i_cfg_valid) begin
            case ({1'b0, i_cfg_index})
                REG_A:   r_cal_a <= i_cfg_data;
                REG_B:   r_cal_b <= i_cfg_data;
                REG_C:   r_cal_c <= i_cfg_data[31:0];
                REG_OSS: r_oss   <= i_cfg_data[1:0];
                default: r_oss   <= r_oss;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_b5     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!r_ovalid || i_m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_kind  <= i_s_axis_tuser;
                        r_raw   <= i_s_axis_tdata;
                        r_temp  <= '0;
                        r_press <= '0;
                        r_err   <= 1'b0;
                        r_b6    <= r_b5 - C_4000;
                        r_state <= i_s_axis_tuser ? S_P0 : S_T0;
                    end
                end
                S_T0: r_state <= S_T1;
                S_T1: begin
                    r_x1  <= w_x1t;
                    r_neg <= w_num[31] ^ w_den[31];
                    if (w_den == '0) begin
                        r_err   <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_TW;
                    end
                end
                S_TW: begin
                    if (w_rsp.done) begin
                        r_b5    <= w_b5n;
                        r_temp  <= w_tn[15:0];
                        r_state <= S_DONE;
                    end
                end
                S_P0: r_state <= S_P1;
                S_P1: begin
                    r_sq    <= bpc_pkg::asr(r_prod, 5'd12);
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_x1    <= bpc_pkg::asr(r_prod, 5'd11);
                    r_state <= S_P3;
                end
                S_P3: begin
                    r_b3    <= w_b3n;
                    r_state <= S_P4;
                end
                S_P4: begin
                    r_x1    <= bpc_pkg::asr(r_prod, 5'd13);
                    r_state <= S_P5;
                end
                S_P5: r_state <= S_P6;
                S_P6: begin
                    r_b4    <= r_prod >> 15;
                    r_state <= S_P7;
                end
                S_P7: begin
                    r_b7 <= r_prod;
                    if (r_b4 == '0) begin
                        r_err   <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_PW;
                    end
                end
                S_PW: begin
                    if (w_rsp.done) begin
                        r_p     <= r_b7[31] ? {w_rsp.quotient[30:0], 1'b0}
                                            : w_rsp.quotient;
                        r_state <= S_P8;
                    end
                end
                S_P8: r_state <= S_P9;
                S_P9: r_state <= S_P10;
                S_P10: begin
                    r_x1    <= bpc_pkg::asr(r_prod, 5'd16);
                    r_state <= S_P11;
                end
                S_P11: begin
                    if (w_pn[31]) begin
                        r_press <= '0;
                    end else if (w_pn > C_PMAX) begin
                        r_press <= C_PMAX[17:0];
                    end else begin
                        r_press <= w_pn[17:0];
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ouser  <= r_kind;
                        r_odata  <= {5'd0, r_err, r_press, r_temp};
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

endmodule

### rtl/bpc_div.sv
// ----------------------------------------------------------------------------
// bpc_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bpc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bpc_pkg::t_div_req i_req,
    output bpc_pkg::t_div_rsp o_rsp
);

    logic                          r_busy;
    logic [bpc_pkg::CNT_W-1:0]     r_cnt;
    bpc_pkg::t_word                r_rem;
    bpc_pkg::t_word                r_quo;
    bpc_pkg::t_word                r_dvs;
    logic                          r_done;
    logic [bpc_pkg::WORD_W:0]      w_sh;
    logic [bpc_pkg::WORD_W:0]      w_diff;

    assign w_sh   = {r_rem, r_quo[bpc_pkg::WORD_W-1]};
    assign w_diff = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                if (!w_diff[bpc_pkg::WORD_W]) begin
                    r_rem <= w_diff[bpc_pkg::WORD_W-1:0];
                    r_quo <= {r_quo[bpc_pkg::WORD_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh[bpc_pkg::WORD_W-1:0];
                    r_quo <= {r_quo[bpc_pkg::WORD_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + bpc_pkg::CNT_W'(1);
                if (r_cnt == bpc_pkg::CNT_W'(bpc_pkg::WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
